// ===== hw/rtl/pblt_pkg.sv =====
`timescale 1ns / 1ps
// pblt_pkg: item structs, request codes and draw mode codes of the palette blitter.
// No dependencies; every other file of the block but pblt_ctab uses it.
package pblt_pkg;

   // Request kinds carried in req_type
   localparam logic [1:0] REQ_PIXEL = 2'd0;
   localparam logic [1:0] REQ_MAP   = 2'd1;
   localparam logic [1:0] REQ_CTAB  = 2'd2;

   // Draw mode codes; every other value is identity
   localparam logic [7:0] MODE_HFLIP  = 8'd129;
   localparam logic [7:0] MODE_VFLIP  = 8'd130;
   localparam logic [7:0] MODE_BOTH   = 8'd131;
   localparam logic [7:0] MODE_ROT90  = 8'd133;
   localparam logic [7:0] MODE_ROT180 = 8'd134;
   localparam logic [7:0] MODE_ROT270 = 8'd135;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [6:0]  pos_x;
      logic [6:0]  pos_y;
      logic [3:0]  colour_index;
      logic [7:0]  table_slot;
      logic [15:0] table_word;
   } req_item_type;

   typedef struct packed {
      logic [13:0] target_address;
      logic [15:0] display_colour;
   } rsp_item_type;

endpackage

// ===== hw/rtl/pblt_place.sv =====
`timescale 1ns / 1ps
// pblt_place: target address of a pixel under the current draw mode.
// Depends on pblt_pkg for the mode codes.
module pblt_place #(
   parameter int SCREEN_SIDE = 128
) (
   input  logic [6:0]  pos_x,
   input  logic [6:0]  pos_y,
   input  logic [7:0]  draw_mode,
   output logic [13:0] target_address
);
   import pblt_pkg::*;

   localparam int CW = $clog2(SCREEN_SIDE);
   localparam logic [8:0]    SIDE = 9'(SCREEN_SIDE);
   localparam logic [CW-1:0] LAST = CW'(SCREEN_SIDE - 1);

   logic [CW-1:0] x_w;
   logic [CW-1:0] y_w;
   logic [CW-1:0] row;
   logic [CW-1:0] col;
   logic [16:0]   offset;

   // Wrap positions into the side; at most eight subtractions for a 7-bit value
   always_comb begin
      logic [8:0] xr;
      logic [8:0] yr;
      xr = {2'b00, pos_x};
      yr = {2'b00, pos_y};
      for (int i = 0; i < 8; i++) begin
         if (xr >= SIDE) xr = xr - SIDE;
         if (yr >= SIDE) yr = yr - SIDE;
      end
      x_w = xr[CW-1:0];
      y_w = yr[CW-1:0];
   end

   always_comb begin
      unique case (draw_mode)
         MODE_HFLIP: begin
            row = y_w;
            col = LAST - x_w;
         end
         MODE_VFLIP: begin
            row = LAST - y_w;
            col = x_w;
         end
         MODE_BOTH, MODE_ROT180: begin
            row = LAST - y_w;
            col = LAST - x_w;
         end
         MODE_ROT90: begin
            row = x_w;
            col = LAST - y_w;
         end
         MODE_ROT270: begin
            row = LAST - x_w;
            col = y_w;
         end
         default: begin
            row = y_w;
            col = x_w;
         end
      endcase
   end

   assign offset = 17'(row) * 17'(SIDE) + 17'(col);
   assign target_address = offset[13:0];

endmodule

// ===== hw/rtl/pblt_ctab.sv =====
`timescale 1ns / 1ps
// pblt_ctab: colour table memory, one write and one registered read port.
// No package dependencies.
module pblt_ctab #(
   parameter int COLOUR_ENTRIES = 144
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(COLOUR_ENTRIES)-1:0] wr_addr,
   input  logic [15:0]                       wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(COLOUR_ENTRIES)-1:0] rd_addr,
   output logic [15:0]                       rd_data
);

   logic [15:0] mem [COLOUR_ENTRIES];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // Hold the read data while the stage after it is stalled
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/palette_blit_with_orientation_top.sv =====
`timescale 1ns / 1ps
// palette_blit_with_orientation_top: indexed pixel to display colour and address.
// Depends on pblt_pkg, pblt_place and pblt_ctab.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+------------------------------
//   req     | in        | req_valid/stall  | pblt_pkg::req_item_type
//   rsp     | out       | rsp_valid/stall  | pblt_pkg::rsp_item_type
//   csr     | in        | csr_valid/ready  | draw_mode, 8 bits
//
// Throughput is one item per clock while rsp_stall is low. A pixel item first sits in
// the input register, where the screen map lookup and the address run; it then loads
// the colour table read register, which is also the result register and drives rsp.
// Reset clears the valid bits and draw_mode; screen map and colour table are
// not cleared and hold garbage until loaded.
// rsp_stall holds the result; a pixel behind it stalls req, load items retire.
module palette_blit_with_orientation_top #(
   parameter int SCREEN_SIDE    = 128,
   parameter int COLOUR_ENTRIES = 144
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pblt_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pblt_pkg::rsp_item_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data
);
   import pblt_pkg::*;

   localparam int AW = $clog2(COLOUR_ENTRIES);
   localparam logic [8:0] ENTRIES = 9'(COLOUR_ENTRIES);

   // Control state
   logic         s1_valid_ff, s1_valid_in;
   logic         s2_valid_ff, s2_valid_in;
   logic [7:0]   draw_mode_ff;

   // Payload state
   req_item_type s1_item_ff;
   logic [13:0]  s2_addr_ff;
   logic         s2_in_range_ff;
   logic [7:0]   screen_map_ff [16];

   logic         accept;
   logic         s1_is_pixel;
   logic         s1_leave;
   logic         s2_advance;
   logic         pixel_go;
   logic [7:0]   map_slot;
   logic         map_in_range;
   logic         ctab_wr_en;
   logic         map_wr_en;
   logic [13:0]  place_addr;
   logic [15:0]  ctab_data;

   // Config port never pushes back
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_mode_ff <= 8'd0;
      end else if (csr_valid) begin
         draw_mode_ff <= csr_data;
      end
   end

   // Handshake: the result stage advances when empty or taken; loads in the
   // input register retire at once, pixels only when the result stage moves
   assign s1_is_pixel = s1_item_ff.req_type == REQ_PIXEL;
   assign s2_advance  = !s2_valid_ff || !rsp_stall;
   assign s1_leave    = s1_valid_ff && (!s1_is_pixel || s2_advance);
   assign pixel_go    = s1_valid_ff && s1_is_pixel && s2_advance;
   assign req_stall   = s1_valid_ff && !s1_leave;
   assign accept      = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) s1_valid_in = 1'b1;
      else if (s1_leave) s1_valid_in = 1'b0;
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (pixel_go) s2_valid_in = 1'b1;
      else if (s2_advance) s2_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) s1_item_ff <= req_item;
   end

   // Loads write as they leave the input register, so a pixel right behind
   // a load already sees the new entry
   assign map_wr_en  = s1_valid_ff && s1_item_ff.req_type == REQ_MAP;
   assign ctab_wr_en = s1_valid_ff && s1_item_ff.req_type == REQ_CTAB
                       && {1'b0, s1_item_ff.table_slot} < ENTRIES;

   always_ff @(posedge clock) begin
      if (map_wr_en) screen_map_ff[s1_item_ff.colour_index] <= s1_item_ff.table_slot;
   end

   // Screen map lookup feeds the colour table read address
   assign map_slot     = screen_map_ff[s1_item_ff.colour_index];
   assign map_in_range = {1'b0, map_slot} < ENTRIES;

   pblt_place #(
      .SCREEN_SIDE(SCREEN_SIDE)
   ) u_place (
      .pos_x         (s1_item_ff.pos_x),
      .pos_y         (s1_item_ff.pos_y),
      .draw_mode     (draw_mode_ff),
      .target_address(place_addr)
   );

   pblt_ctab #(
      .COLOUR_ENTRIES(COLOUR_ENTRIES)
   ) u_ctab (
      .clock  (clock),
      .wr_en  (ctab_wr_en),
      .wr_addr(s1_item_ff.table_slot[AW-1:0]),
      .wr_data(s1_item_ff.table_word),
      .rd_en  (pixel_go),
      .rd_addr(map_slot[AW-1:0]),
      .rd_data(ctab_data)
   );

   // Hold address and range flag alongside the table read data
   always_ff @(posedge clock) begin
      if (pixel_go) begin
         s2_addr_ff     <= place_addr;
         s2_in_range_ff <= map_in_range;
      end
   end

   // Drop the colour when the map points past the table
   assign rsp_valid                = s2_valid_ff;
   assign rsp_item.target_address  = s2_addr_ff;
   assign rsp_item.display_colour  = s2_in_range_ff ? ctab_data : 16'd0;

endmodule

// ===== hw/rtl/pblt_checker.sv =====
`timescale 1ns / 1ps
// pblt_checker: port-level assertions for the palette blitter, bound to the top.
// Depends on pblt_pkg for the item structs.
module pblt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input pblt_pkg::req_item_type req_item,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input pblt_pkg::rsp_item_type rsp_item,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [7:0]             csr_data
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // Input backpressure only comes from a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a stalled result");

   // A fresh result stems from an item that was accepted and then left the input register without waiting
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching accepted item");

   // Config writes are never refused
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("config write refused");

endmodule

bind palette_blit_with_orientation_top pblt_checker u_checker (.*);

// ===== bench/tb_palette_blit_with_orientation_top.sv =====
`timescale 1ns / 1ps
// tb_palette_blit_with_orientation_top: self-checking bench for the palette blitter.
// Depends on pblt_pkg and palette_blit_with_orientation_top; predicts every pixel result.
module tb_palette_blit_with_orientation_top;
   import pblt_pkg::*;

   localparam int TABLE_DEPTH   = 144;
   localparam int SETTLE_CYCLES = 4;       // two pipeline stages plus margin
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1650;
   localparam int PHASE_ITEMS   = 250;
   localparam int HOLD_CYCLES   = 200;

   localparam logic [6:0] LAST_POS       = 7'd127;
   // Identity codes worth hitting: both range ends and the hole between the rotations
   localparam logic [7:0] MODE_IDENT_LOW  = 8'd0;
   localparam logic [7:0] MODE_IDENT_GAP  = 8'd132;
   localparam logic [7:0] MODE_IDENT_HIGH = 8'd255;
   localparam logic [7:0] MODE_IDENT_LAST = 8'd128;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data  = 8'd0;

   // Shadow copy of the block's state, updated at each accepted item
   logic [7:0]   map_shadow  [16];
   logic [15:0]  ctab_shadow [TABLE_DEPTH];
   bit           map_loaded  [16];
   bit           ctab_loaded [TABLE_DEPTH];
   logic [7:0]   mode_shadow = MODE_IDENT_LOW;

   rsp_item_type pending_pixels [$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           hold_left   = 0;
   int           stall_left  = 0;
   bit           send_gaps   = 1'b0;
   bit           rsp_gaps    = 1'b0;

   palette_blit_with_orientation_top #(
      .SCREEN_SIDE    (128),
      .COLOUR_ENTRIES (TABLE_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Map a pixel position onto the frame according to the current draw mode.
   // Row and column are 7 bits each, so row * 128 + column is just {row, column}.
   function automatic logic [13:0] oriented_address(logic [6:0] x, logic [6:0] y);
      logic [6:0] row;
      logic [6:0] col;
      case (mode_shadow)
         MODE_HFLIP: begin
            row = y;            col = LAST_POS - x;
         end
         MODE_VFLIP: begin
            row = LAST_POS - y; col = x;
         end
         MODE_BOTH, MODE_ROT180: begin
            row = LAST_POS - y; col = LAST_POS - x;
         end
         MODE_ROT90: begin
            row = x;            col = LAST_POS - y;
         end
         MODE_ROT270: begin
            row = LAST_POS - x; col = y;
         end
         default: begin
            row = y;            col = x;
         end
      endcase
      return {row, col};
   endfunction

   // A pixel may only read map and table entries that were loaded before.
   function automatic bit pixel_is_safe(logic [3:0] idx);
      return map_loaded[idx] &&
             (map_shadow[idx] >= TABLE_DEPTH || ctab_loaded[map_shadow[idx]]);
   endfunction

   // Fill every field with noise, then fix the kind; callers overwrite what matters.
   function automatic req_item_type random_item(logic [1:0] kind);
      req_item_type it;
      it.req_type     = kind;
      it.pos_x        = 7'($urandom);
      it.pos_y        = 7'($urandom);
      it.colour_index = 4'($urandom);
      it.table_slot   = 8'($urandom);
      it.table_word   = 16'($urandom);
      return it;
   endfunction

   function automatic req_item_type pixel_item(logic [6:0] x, logic [6:0] y, logic [3:0] idx);
      req_item_type it;
      it              = random_item(REQ_PIXEL);
      it.pos_x        = x;
      it.pos_y        = y;
      it.colour_index = idx;
      return it;
   endfunction

   // Random pixel that reads only loaded entries; call once the tables are full.
   function automatic req_item_type random_pixel();
      req_item_type it;
      it = random_item(REQ_PIXEL);
      while (!pixel_is_safe(it.colour_index))
         it.colour_index = 4'($urandom);
      return it;
   endfunction

   function automatic req_item_type map_item(logic [3:0] idx, logic [7:0] value);
      req_item_type it;
      it              = random_item(REQ_MAP);
      it.colour_index = idx;
      it.table_slot   = value;
      return it;
   endfunction

   function automatic req_item_type ctab_item(logic [7:0] slot, logic [15:0] word);
      req_item_type it;
      it            = random_item(REQ_CTAB);
      it.table_slot = slot;
      it.table_word = word;
      return it;
   endfunction

   // Offer one item after a random gap if send_gaps is set, wait for acceptance, then
   // update the shadow state. Leave valid high so a back-to-back item only swaps the payload.
   task automatic send_item(input req_item_type it);
      int           gap;
      rsp_item_type want;
      logic [7:0]   entry;
      gap = send_gaps ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      case (it.req_type)
         REQ_PIXEL: begin
            entry                = map_shadow[it.colour_index];
            want.target_address  = oriented_address(it.pos_x, it.pos_y);
            want.display_colour  = (entry < TABLE_DEPTH) ? ctab_shadow[entry] : 16'd0;
            pending_pixels.insert(pending_pixels.size(), want);
         end
         REQ_MAP: begin
            map_shadow[it.colour_index] = it.table_slot;
            map_loaded[it.colour_index] = 1'b1;
         end
         REQ_CTAB: begin
            // Slots past the table are dropped by the block
            if (it.table_slot < TABLE_DEPTH) begin
               ctab_shadow[it.table_slot] = it.table_word;
               ctab_loaded[it.table_slot] = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   // Stop sending and wait for every pending pixel, then let any load item
   // still in the pipe retire.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write draw_mode with the block idle.
   task automatic write_draw_mode(input logic [7:0] mode);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      mode_shadow = mode;
   endtask

   // Table extremes, map values past the table, frame corners, the unused kind.
   task automatic test_directed();
      send_item(map_item(4'd0, 8'd0));
      send_item(map_item(4'd15, 8'd143));
      send_item(map_item(4'd1, 8'd144));     // past the table: colour reads as zero
      send_item(map_item(4'd2, 8'd255));
      send_item(ctab_item(8'd0, 16'hFFFF));
      send_item(ctab_item(8'd143, 16'h0000));
      send_item(ctab_item(8'd144, 16'h5A5A)); // dropped
      send_item(ctab_item(8'd255, 16'hA5A5)); // dropped
      send_item(pixel_item(7'd0, 7'd0, 4'd0));
      send_item(pixel_item(LAST_POS, LAST_POS, 4'd15));
      send_item(pixel_item(LAST_POS, 7'd0, 4'd1));
      send_item(pixel_item(7'd0, LAST_POS, 4'd2));
      send_item(random_item(2'd3));           // unused kind: no result
      send_item(ctab_item(8'd0, 16'h0000));
      send_item(pixel_item(7'd64, 7'd1, 4'd0));
      send_item(map_item(4'd15, 8'd0));
      send_item(pixel_item(7'd1, 7'd64, 4'd15));
   endtask

   // Load every table entry and every map slot so random pixels are always legal.
   task automatic test_table_load();
      for (int slot = 0; slot < TABLE_DEPTH; slot++)
         send_item(ctab_item(8'(slot), 16'($urandom)));
      for (int idx = 0; idx < 16; idx++)
         send_item(map_item(4'(idx), 8'($urandom_range(0, 159))));
   endtask

   // Walk all orientations and a few identity codes, corners first.
   task automatic test_orientations();
      logic [7:0] modes [10];
      modes = '{MODE_HFLIP, MODE_VFLIP, MODE_BOTH, MODE_ROT90, MODE_ROT180,
                MODE_ROT270, MODE_IDENT_GAP, MODE_IDENT_LAST, MODE_IDENT_HIGH,
                MODE_IDENT_LOW};
      foreach (modes[m]) begin
         write_draw_mode(modes[m]);
         send_item(pixel_item(7'd0, 7'd0, 4'($urandom)));
         send_item(pixel_item(LAST_POS, 7'd0, 4'($urandom)));
         send_item(pixel_item(7'd0, LAST_POS, 4'($urandom)));
         send_item(pixel_item(LAST_POS, LAST_POS, 4'($urandom)));
         repeat (8) send_item(random_pixel());
      end
   endtask

   // Hold the result side off for a long stretch while pixels keep coming,
   // so the pipe fills and the block stalls its input.
   task automatic test_backpressure();
      send_gaps = 1'b0;
      rsp_gaps  = 1'b0;
      hold_left <= HOLD_CYCLES;
      repeat (40) send_item(random_pixel());
   endtask

   // Pause the sender until everything is back, then burst again.
   task automatic test_pause_and_burst();
      drain_results();
      repeat (20) send_item(random_pixel());
   endtask

   // Random mix with a new draw mode and a new idling pattern every phase.
   task automatic test_random_mix();
      int         pick;
      logic [7:0] mode;
      logic [7:0] named [6];
      named = '{MODE_HFLIP, MODE_VFLIP, MODE_BOTH, MODE_ROT90, MODE_ROT180, MODE_ROT270};
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_ITEMS == 0) begin
            mode = $urandom_range(0, 1) ? named[$urandom_range(0, 5)] : 8'($urandom);
            write_draw_mode(mode);
            // Rotate through: both idle, none idle, sender only, receiver only
            send_gaps = ((i / PHASE_ITEMS) % 4) inside {0, 2};
            rsp_gaps  = ((i / PHASE_ITEMS) % 4) inside {0, 3};
         end
         pick = $urandom_range(0, 99);
         if (pick < 72)
            send_item(random_pixel());
         else if (pick < 84)
            send_item(map_item(4'($urandom), $urandom_range(0, 3) == 0 ?
                               8'($urandom) : 8'($urandom_range(0, TABLE_DEPTH - 1))));
         else if (pick < 96)
            send_item(ctab_item($urandom_range(0, 7) == 0 ?
                                8'($urandom) : 8'($urandom_range(0, TABLE_DEPTH - 1)),
                                16'($urandom)));
         else
            send_item(random_item(2'd3));
      end
   endtask

   // Result side: check each accepted item against the oldest prediction, then
   // draw the stall before the next one. A long hold overrides the drawn stall.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, actual addr %0d colour %h",
                        $realtime, rsp_item.target_address, rsp_item.display_colour);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_item.target_address !== want.target_address) begin
                  error_count++;
                  $display("%0t: target_address expected %0d actual %0d",
                           $realtime, want.target_address, rsp_item.target_address);
               end
               if (rsp_item.display_colour !== want.display_colour) begin
                  error_count++;
                  $display("%0t: display_colour expected %h actual %h",
                           $realtime, want.display_colour, rsp_item.display_colour);
               end
            end
            stall_left = rsp_gaps ? $urandom_range(0, 8) : 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Count down the long hold in its own process
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // Watchdog: end the run if it takes far longer than any correct run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_gaps = 1'b1;
      rsp_gaps  = 1'b1;
      test_directed();
      test_table_load();
      test_orientations();
      test_backpressure();
      test_pause_and_burst();
      test_random_mix();
      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
